>>> hdl/wpm_pkg.sv
// Shared types and constants of the 3x3 window pattern matcher.
`default_nettype none

package wpm_pkg;

  // Field widths of the channels and registers
  localparam int unsigned PIXEL_W   = 8;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned PATTERN_W = 24;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned COL_OUT_W = 10;
  localparam int unsigned COUNT_W   = 20;

  // Window and frame limits
  localparam int unsigned WIN        = 3;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = PATTERN_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BOTTOM = 3'd4;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 3;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef struct packed {
    logic                 found;
    logic [ROW_W-1:0]     match_row;
    logic [COL_OUT_W-1:0] match_col;
    logic [COUNT_W-1:0]   match_count;
    logic                 frame_end;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/wpm_if.sv
// Pixel and result channel interfaces of the window pattern matcher.
`default_nettype none

interface wpm_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [wpm_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface wpm_result_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [wpm_pkg::ROW_W-1:0]     match_row;
  logic [wpm_pkg::COL_OUT_W-1:0] match_col;
  logic [wpm_pkg::COUNT_W-1:0]   match_count;
  logic                          frame_end;

  modport source (output valid, output found, output match_row, output match_col,
                  output match_count, output frame_end, input ready);
  modport sink (input valid, input found, input match_row, input match_col,
                input match_count, input frame_end, output ready);
endinterface

`default_nettype wire

>>> hdl/wpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/wpm_result_fifo.sv
// Three-entry result queue that drives the result channel.
`default_nettype none

module wpm_result_fifo (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push_i,
  input  wire wpm_pkg::result_t                   push_data_i,
  output logic      [wpm_pkg::FIFO_CNT_W-1:0]     count_o,
  wpm_result_if.source                            res_out
);

  localparam logic [wpm_pkg::FIFO_PTR_W-1:0] LAST_PTR =
    wpm_pkg::FIFO_PTR_W'(wpm_pkg::FIFO_DEPTH - 1);

  wpm_pkg::result_t                    entry_q [wpm_pkg::FIFO_DEPTH];
  logic [wpm_pkg::FIFO_PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [wpm_pkg::FIFO_PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [wpm_pkg::FIFO_CNT_W-1:0]      cnt_q, cnt_d;
  logic                                pop;
  wpm_pkg::result_t                    head;

  assign pop = res_out.valid && res_out.ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed result
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Present the oldest result
  assign head                = entry_q[rd_ptr_q];
  assign res_out.valid       = (cnt_q != '0);
  assign res_out.found       = head.found;
  assign res_out.match_row   = head.match_row;
  assign res_out.match_col   = head.match_col;
  assign res_out.match_count = head.match_count;
  assign res_out.frame_end   = head.frame_end;
  assign count_o             = cnt_q;

endmodule

`default_nettype wire

>>> hdl/window_pattern_matcher_3x3.sv
// Top level of the 3x3 exact window pattern matcher.
// Takes one image byte per cycle in row-major order and reports every 3x3 window
// that equals the configured pattern, plus one frame-end result on the last pixel
// of each frame. A pixel request is taken in the cycle it is offered as long as the
// result queue has room; with the result side always ready the block sustains one
// pixel per cycle. The accept cycle issues a pixel's line-buffer read; the next cycle
// updates the window, writes the line buffers back and compares, and any result is then
// pushed into the result queue that drives the output. Two line buffers of MAX_WIDTH
// bytes hold the previous two rows; they need no clearing after reset. Size and pattern
// registers must be written only while idle; the block itself does not enforce this.
`default_nettype none

module window_pattern_matcher_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [wpm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [wpm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  wpm_pixel_if.sink                               pix_in,
  wpm_result_if.source                            res_out
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (CNT_W > wpm_pkg::SIZE_W) ? CNT_W : wpm_pkg::SIZE_W;
  localparam int unsigned PW    = wpm_pkg::PIXEL_W;
  localparam int unsigned RW    = wpm_pkg::ROW_W;
  localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] WIN_C   = CMP_W'(wpm_pkg::WIN);
  localparam logic [wpm_pkg::SIZE_W-1:0] MAX_H_C  = wpm_pkg::SIZE_W'(wpm_pkg::MAX_HEIGHT);
  localparam logic [wpm_pkg::SIZE_W-1:0] WIN_H_C  = wpm_pkg::SIZE_W'(wpm_pkg::WIN);

  // Configuration registers
  logic [wpm_pkg::SIZE_W-1:0]    width_q, height_q;
  logic [wpm_pkg::PATTERN_W-1:0] pat_top_q, pat_mid_q, pat_bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= wpm_pkg::SIZE_W'(wpm_pkg::WIN);
      height_q  <= wpm_pkg::SIZE_W'(wpm_pkg::WIN);
      pat_top_q <= '0;
      pat_mid_q <= '0;
      pat_bot_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wpm_pkg::CFG_IMAGE_WIDTH:    width_q   <= cfg_wdata_i[wpm_pkg::SIZE_W-1:0];
        wpm_pkg::CFG_IMAGE_HEIGHT:   height_q  <= cfg_wdata_i[wpm_pkg::SIZE_W-1:0];
        wpm_pkg::CFG_PATTERN_TOP:    pat_top_q <= cfg_wdata_i;
        wpm_pkg::CFG_PATTERN_MIDDLE: pat_mid_q <= cfg_wdata_i;
        wpm_pkg::CFG_PATTERN_BOTTOM: pat_bot_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the frame size
  logic [CMP_W-1:0]          width_ext, width_eff;
  logic [wpm_pkg::SIZE_W-1:0] height_eff;

  assign width_ext = CMP_W'(width_q);

  always_comb begin
    priority if (width_ext < WIN_C) begin
      width_eff = WIN_C;
    end else if (width_ext > MAX_W_C) begin
      width_eff = MAX_W_C;
    end else begin
      width_eff = width_ext;
    end
    priority if (height_q < WIN_H_C) begin
      height_eff = WIN_H_C;
    end else if (height_q > MAX_H_C) begin
      height_eff = MAX_H_C;
    end else begin
      height_eff = height_q;
    end
  end

  // Accept stage: position tracking
  logic                        accept;
  logic [COL_W-1:0]            col_q, col_d;
  logic [RW-1:0]               row_q, row_d;
  logic                        row_end, frame_last;
  logic [wpm_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic [wpm_pkg::FIFO_CNT_W:0]   credits;
  logic                        s1_valid_q;

  assign credits      = {1'b0, fifo_cnt} + {{wpm_pkg::FIFO_CNT_W{1'b0}}, s1_valid_q};
  assign pix_in.ready = (credits < (wpm_pkg::FIFO_CNT_W + 1)'(wpm_pkg::FIFO_DEPTH));
  assign accept       = pix_in.valid && pix_in.ready;

  assign row_end    = (CMP_W'(col_q) + 1'b1) >= width_eff;
  assign frame_last = row_end && ((wpm_pkg::SIZE_W'(row_q) + 1'b1) >= height_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      priority if (frame_last) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Hold the accepted request for the window stage
  logic [PW-1:0]    s1_pixel_q;
  logic [COL_W-1:0] s1_col_q;
  logic [RW-1:0]    s1_row_q;
  logic             s1_last_q;
  logic             s1_corner_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q  <= pix_in.pixel;
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_last_q   <= frame_last;
      s1_corner_q <= (CMP_W'(col_q) >= CMP_W'(2)) && (row_q >= RW'(2));
    end
  end

  // Line buffers: a holds the row above, b the row two above
  logic [PW-1:0] above1, above2;

  wpm_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pixel_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (above1)
  );

  wpm_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (above1),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (above2)
  );

  // Shift the window and compare against the pattern
  logic [wpm_pkg::PATTERN_W-1:0] win_q [wpm_pkg::WIN];
  logic [wpm_pkg::PATTERN_W-1:0] win_d [wpm_pkg::WIN];
  logic                          match;

  always_comb begin
    win_d[0] = {above2,     win_q[0][wpm_pkg::PATTERN_W-1:PW]};
    win_d[1] = {above1,     win_q[1][wpm_pkg::PATTERN_W-1:PW]};
    win_d[2] = {s1_pixel_q, win_q[2][wpm_pkg::PATTERN_W-1:PW]};
  end

  assign match = s1_corner_q && (win_d[0] == pat_top_q) && (win_d[1] == pat_mid_q) &&
                 (win_d[2] == pat_bot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  // Count matches, saturating, and drop the count at frame end
  logic [wpm_pkg::COUNT_W-1:0] found_q, found_inc;

  assign found_inc = (match && (found_q != wpm_pkg::COUNT_MAX)) ? found_q + 1'b1 : found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else if (s1_valid_q) begin
      found_q <= s1_last_q ? '0 : found_inc;
    end
  end

  // Build the result and push it into the queue
  wpm_pkg::result_t result;
  logic             push;

  always_comb begin
    result.found       = match;
    result.match_row   = match ? s1_row_q - RW'(2) : '0;
    result.match_col   = match ? wpm_pkg::COL_OUT_W'(s1_col_q - COL_W'(2)) : '0;
    result.match_count = found_inc;
    result.frame_end   = s1_last_q;
  end

  assign push = s1_valid_q && (match || s1_last_q);

  wpm_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .count_o     (fifo_cnt),
    .res_out     (res_out)
  );

endmodule

`default_nettype wire

>>> tb/sv/wpm_match_checker.sv
// Result checker of the window pattern matcher: predicts every result from the pixel requests.
`timescale 1ns / 100ps

module wpm_match_checker #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wpm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wpm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  wpm_pixel_if                             pix_mon,
  wpm_result_if                            res_mon,
  output int unsigned                      results_due_o,
  output logic                             frame_start_o,
  output int unsigned                      mismatches_o
);
  import wpm_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow copy of the size and pattern registers
  logic [SIZE_W-1:0]    width_reg;
  logic [SIZE_W-1:0]    height_reg;
  logic [PATTERN_W-1:0] pat_top;
  logic [PATTERN_W-1:0] pat_middle;
  logic [PATTERN_W-1:0] pat_bottom;

  // Predicted image state: two previous rows, the 3x3 window and the scan position
  logic [PIXEL_W-1:0]   row_above [MAX_WIDTH];
  logic [PIXEL_W-1:0]   row_two_above [MAX_WIDTH];
  logic [PATTERN_W-1:0] window_rows [WIN];
  logic [ROW_W-1:0]     row_pos;
  logic [COL_OUT_W-1:0] col_pos;
  logic [COUNT_W-1:0]   frame_matches;

  result_t     due_results [$];
  int unsigned mismatch_total;

  // Effective frame size: registers below the window size or above the given ceiling are clamped
  function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] code,
                                            input int unsigned ceiling);
    if (code < WIN) return WIN;
    if (code > ceiling) return ceiling;
    return code;
  endfunction

  // Advance the image by one pixel and queue the result it causes, if any
  task automatic scan_pixel(input logic [PIXEL_W-1:0] px);
    int unsigned     w;
    int unsigned     h;
    int unsigned     idx;
    logic [PIXEL_W-1:0] up2;
    logic [PIXEL_W-1:0] up1;
    logic            hit;
    logic            last;
    result_t         want;
    w    = clamp_dim(width_reg, MAX_WIDTH);
    h    = clamp_dim(height_reg, MAX_HEIGHT);
    idx  = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
    up2  = row_two_above[idx];
    up1  = row_above[idx];
    row_two_above[idx] = up1;
    row_above[idx]     = px;
    // newest byte enters at the top of each window row
    window_rows[0] = {up2, window_rows[0][PATTERN_W-1:PIXEL_W]};
    window_rows[1] = {up1, window_rows[1][PATTERN_W-1:PIXEL_W]};
    window_rows[2] = {px,  window_rows[2][PATTERN_W-1:PIXEL_W]};
    hit  = (row_pos >= 2) && (col_pos >= 2) && (window_rows[0] == pat_top) &&
           (window_rows[1] == pat_middle) && (window_rows[2] == pat_bottom);
    last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
    // hold the count at its ceiling
    if (hit && frame_matches != COUNT_MAX) frame_matches = frame_matches + 1'b1;
    if (hit || last) begin
      want.found       = hit;
      want.match_row   = hit ? row_pos - ROW_W'(2) : '0;
      want.match_col   = hit ? col_pos - COL_OUT_W'(2) : '0;
      want.match_count = frame_matches;
      want.frame_end   = last;
      due_results.push_back(want);
    end
    if (last) begin
      row_pos       = '0;
      col_pos       = '0;
      frame_matches = '0;
    end else if (col_pos + 1 >= w) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  // Compare one result request with the oldest prediction
  task automatic check_result(input result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT)
        $display("unexpected result: found=%0d row=%0d col=%0d count=%0d end=%0d",
                 got.found, got.match_row, got.match_col, got.match_count, got.frame_end);
    end else begin
      want = due_results.pop_front();
      if (got.found !== want.found || got.match_row !== want.match_row ||
          got.match_col !== want.match_col || got.match_count !== want.match_count ||
          got.frame_end !== want.frame_end) begin
        mismatch_total++;
        if (mismatch_total <= REPORT_LIMIT)
          $display({"result mismatch: expected found=%0d row=%0d col=%0d count=%0d end=%0d,",
                    " got found=%0d row=%0d col=%0d count=%0d end=%0d"},
                   want.found, want.match_row, want.match_col, want.match_count,
                   want.frame_end, got.found, got.match_row, got.match_col,
                   got.match_count, got.frame_end);
      end
    end
  endtask

  // Track register writes, predict on pixel requests, check result requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg      = SIZE_W'(WIN);
      height_reg     = SIZE_W'(WIN);
      pat_top        = '0;
      pat_middle     = '0;
      pat_bottom     = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i]     = '0;
        row_two_above[i] = '0;
      end
      for (int i = 0; i < WIN; i++) window_rows[i] = '0;
      row_pos        = '0;
      col_pos        = '0;
      frame_matches  = '0;
      mismatch_total = 0;
      due_results.delete();
      results_due_o <= 0;
      frame_start_o <= 1'b1;
      mismatches_o  <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready)
        check_result('{found: res_mon.found, match_row: res_mon.match_row,
                       match_col: res_mon.match_col, match_count: res_mon.match_count,
                       frame_end: res_mon.frame_end});
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:    width_reg  = cfg_wdata_i[SIZE_W-1:0];
          CFG_IMAGE_HEIGHT:   height_reg = cfg_wdata_i[SIZE_W-1:0];
          CFG_PATTERN_TOP:    pat_top    = cfg_wdata_i[PATTERN_W-1:0];
          CFG_PATTERN_MIDDLE: pat_middle = cfg_wdata_i[PATTERN_W-1:0];
          CFG_PATTERN_BOTTOM: pat_bottom = cfg_wdata_i[PATTERN_W-1:0];
          default: ;
        endcase
      end
      if (pix_mon.valid && pix_mon.ready) scan_pixel(pix_mon.pixel);
      results_due_o <= due_results.size();
      frame_start_o <= (row_pos == '0) && (col_pos == '0);
      mismatches_o  <= mismatch_total;
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Testbench top of the window pattern matcher: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import wpm_pkg::*;

  localparam int unsigned MAX_WIDTH      = 1024;
  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_PIXELS  = 800;
  localparam int unsigned CALM_FROM      = 650;
  localparam int unsigned MAX_BURST      = 18;
  localparam int unsigned TALL_ROWS      = 40;

  typedef enum int unsigned {
    CONTENT_NOISE,
    CONTENT_TWO_SYMBOL,
    CONTENT_UNIFORM
  } content_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wpm_pixel_if  pix_if ();
  wpm_result_if res_if ();

  int unsigned results_due;
  int unsigned mismatch_count;
  logic        frame_start;

  // Idling controls
  int unsigned gap_odds;
  int unsigned stall_odds;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  bit          calm;

  // Stimulus state
  int unsigned        frame_w;
  int unsigned        frame_h;
  int unsigned        pixels_sent;
  logic [PATTERN_W-1:0] pattern_rows [WIN];
  logic [PIXEL_W-1:0] frame_pixels [$];
  logic [PIXEL_W-1:0] sym_a;
  logic [PIXEL_W-1:0] sym_b;
  content_e           content;
  bit                 need_setup;

  window_pattern_matcher_3x3 #(
    .MAX_WIDTH (MAX_WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .pix_in      (pix_if),
    .res_out     (res_if)
  );

  wpm_match_checker #(
    .MAX_WIDTH (MAX_WIDTH)
  ) match_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .pix_mon       (pix_if),
    .res_mon       (res_if),
    .results_due_o (results_due),
    .frame_start_o (frame_start),
    .mismatches_o  (mismatch_count)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Stall the result side in bursts, never once the run is calm
  always @(posedge clk_i) begin
    if (calm || stall_odds == 0) begin
      res_if.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(1, stall_odds) == 1) begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, MAX_BURST - 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel request, after an optional gap, and hold it until taken
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    do @(posedge clk_i); while (!pix_if.ready);
    pixels_sent++;
  endtask

  // Hold off the pixel side until every predicted result has arrived and the pipe is empty
  task automatic wait_quiet();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Write all five registers back to back
  task automatic program_block(input logic [SIZE_W-1:0] w_code, input logic [SIZE_W-1:0] h_code);
    write_reg(CFG_IMAGE_WIDTH, w_code);
    write_reg(CFG_IMAGE_HEIGHT, h_code);
    write_reg(CFG_PATTERN_TOP, pattern_rows[0]);
    write_reg(CFG_PATTERN_MIDDLE, pattern_rows[1]);
    write_reg(CFG_PATTERN_BOTTOM, pattern_rows[2]);
    cfg_we <= 1'b0;
  endtask

  // Register code for a size: the minimum is sometimes given as an under-range value
  function automatic logic [SIZE_W-1:0] size_code(input int unsigned dim);
    if (dim == WIN && $urandom_range(0, 1) == 1) return SIZE_W'($urandom_range(0, WIN - 1));
    return SIZE_W'(dim);
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_byte();
    case (content)
      CONTENT_NOISE:      return PIXEL_W'($urandom_range(0, 255));
      CONTENT_TWO_SYMBOL: return ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
      default:            return ($urandom_range(0, 7) == 0) ? PIXEL_W'($urandom_range(0, 255))
                                                             : sym_a;
    endcase
  endfunction

  // Feed single requests until the frame closes
  task automatic finish_frame();
    do begin
      send_pixel(pick_byte());
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end while (!frame_start);
  endtask

  // Build a frame with planted pattern copies and stream it; a broken frame shrinks midway
  task automatic run_frame(input bit broken);
    int unsigned r0;
    int unsigned c0;
    int unsigned cut;
    frame_pixels.delete();
    repeat (frame_w * frame_h) frame_pixels.push_back(pick_byte());
    repeat ($urandom_range(0, 3)) begin
      r0 = $urandom_range(0, frame_h - WIN);
      c0 = $urandom_range(0, frame_w - WIN);
      for (int i = 0; i < WIN; i++)
        for (int j = 0; j < WIN; j++)
          frame_pixels[(r0 + i) * frame_w + c0 + j] = pattern_rows[i][8 * j +: 8];
    end
    cut = broken ? $urandom_range(1, frame_w * frame_h - 1) : frame_w * frame_h;
    for (int k = 0; k < cut; k++) send_pixel(frame_pixels[k]);
    if (broken) begin
      wait_quiet();
      frame_w = $urandom_range(WIN, frame_w);
      frame_h = $urandom_range(WIN, frame_h);
      program_block(size_code(frame_w), size_code(frame_h));
      finish_frame();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_IMAGE_WIDTH;
    cfg_wdata    = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b1;
    stall_odds   = 4;
    gap_odds     = 0;
    calm         = 1'b0;
    pixels_sent  = 0;
    content      = CONTENT_NOISE;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setup: zero pattern on a 3x3 frame of zeros, match on the frame's last pixel
    repeat (9) send_pixel(8'h00);
    wait_quiet();

    // Shrink width and height mid-frame (height below the minimum); no match at frame end
    for (int i = 0; i < WIN; i++) pattern_rows[i] = 24'hFFFFFF;
    program_block(11'd5, 11'd4);
    repeat (6) send_pixel(8'hFF);
    wait_quiet();
    program_block(11'd3, 11'd2);
    repeat (4) send_pixel(8'hFF);
    send_pixel(8'h00);

    // Widest row through an over-range width code, then narrow the frame to close it
    content = CONTENT_UNIFORM;
    sym_a   = PIXEL_W'($urandom_range(0, 255));
    for (int i = 0; i < WIN; i++) pattern_rows[i] = {WIN{sym_a}};
    wait_quiet();
    frame_w = MAX_WIDTH;
    frame_h = WIN;
    program_block(11'h7FF, 11'd0);
    repeat (MAX_WIDTH + 2 * WIN) send_pixel(pick_byte());
    wait_quiet();
    frame_w = WIN;
    program_block(11'd3, 11'd0);
    finish_frame();

    // Tall frame through an over-range height code, then lower the height to close it
    wait_quiet();
    frame_w = WIN;
    frame_h = MAX_HEIGHT;
    program_block(11'd0, 11'h7FF);
    repeat (WIN * TALL_ROWS) send_pixel(pick_byte());
    wait_quiet();
    frame_h = WIN;
    program_block(11'd0, 11'd3);
    finish_frame();

    // Random frames, mostly small, some broken
    pixels_sent = 0;
    need_setup  = 1'b1;
    while (pixels_sent < RANDOM_PIXELS) begin
      content    = content_e'($urandom_range(0, 2));
      sym_a      = PIXEL_W'($urandom_range(0, 255));
      sym_b      = PIXEL_W'($urandom_range(0, 255));
      gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
      stall_odds <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 15);
      if (pixels_sent >= CALM_FROM) calm <= 1'b1;
      if (need_setup || $urandom_range(0, 2) == 0) begin
        wait_quiet();
        frame_w = ($urandom_range(0, 9) == 0) ? $urandom_range(WIN, 64) : $urandom_range(WIN, 12);
        frame_h = $urandom_range(WIN, 8);
        for (int i = 0; i < WIN; i++)
          for (int j = 0; j < WIN; j++)
            pattern_rows[i][8 * j +: 8] = pick_byte();
        program_block(size_code(frame_w), size_code(frame_h));
        need_setup = 1'b0;
      end
      run_frame(!calm && pixels_sent < CALM_FROM && $urandom_range(0, 7) == 0);
    end

    // Drain and give the verdict
    wait_quiet();
    if (mismatch_count == 0 && results_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
